@@ design/tcgs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tcgs_pkg;

  // Default build-time configuration
  localparam int GLYPH_COLUMNS_DEF = 6;
  localparam int SCALE_DEF         = 1;
  localparam int ROW_STEP_DEF      = 8;
  localparam int GLYPH_COUNT_DEF   = 256;

  // Widest bit replication the expander supports
  localparam int MAX_SCALE = 2;

  // Opcodes of an input item
  localparam logic [2:0] OP_PUT_CHAR    = 3'd0;
  localparam logic [2:0] OP_SET_CURSOR  = 3'd1;
  localparam logic [2:0] OP_SAVE_CURSOR = 3'd2;
  localparam logic [2:0] OP_REST_CURSOR = 3'd3;
  localparam logic [2:0] OP_GLYPH_WRITE = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_WINDOW = 2'd1;
  localparam logic [1:0] KIND_PIXELS = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_BOTTOM = 2'd3;

  // Reset values of the text area
  localparam logic [7:0] AREA_LEFT_RST   = 8'd0;
  localparam logic [7:0] AREA_TOP_RST    = 8'd0;
  localparam logic [7:0] AREA_RIGHT_RST  = 8'd127;
  localparam logic [7:0] AREA_BOTTOM_RST = 8'd63;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic [7:0] text_col;
    logic [7:0] text_row;
    logic [2:0] glyph_column;
    logic [7:0] glyph_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic [7:0] pixel_byte;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

@@ design/text_cursor_glyph_scaler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sequence: an item is taken in the idle state and decoded in the exec state; a
//   put-character item then gives one result per cycle while the output is not stalled
//   (1 + GLYPH_COLUMNS*SCALE*SCALE results, +1 on wrap). A new item is taken only in
//   the idle state, after the last result of the previous one is in the output register.
// Reset: asynchronous, active low; cursors cleared, area set to its defaults.
//   The glyph memory is not cleared and must be written before it is drawn.
module text_cursor_glyph_scaler #(
  parameter int GLYPH_COLUMNS = tcgs_pkg::GLYPH_COLUMNS_DEF,
  parameter int SCALE         = tcgs_pkg::SCALE_DEF,
  parameter int ROW_STEP      = tcgs_pkg::ROW_STEP_DEF,
  parameter int GLYPH_COUNT   = tcgs_pkg::GLYPH_COUNT_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  tcgs_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output tcgs_pkg::out_item_t            out_data_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [tcgs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [7:0]                      cfg_data_i
);
  import tcgs_pkg::*;

  // Derived sizes
  localparam int DEPTH  = GLYPH_COUNT * GLYPH_COLUMNS;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
  localparam int SUBS   = SCALE * SCALE;              // bytes per glyph column
  localparam int SW     = (SUBS > 1) ? $clog2(SUBS) : 1;
  localparam logic [7:0] WIDTH_PX = 8'(GLYPH_COLUMNS * SCALE);
  localparam logic [7:0] STEP_1   = 8'(ROW_STEP);
  localparam logic [7:0] STEP_2   = 8'(2 * ROW_STEP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CLEAR,
    S_WIN,
    S_DATA
  } state_e;

  state_e     state_q;
  in_item_t   item_q;
  out_item_t  out_q;
  logic       out_valid_q;

  // Text area registers
  logic [7:0] area_left_q, area_top_q, area_right_q, area_bottom_q;

  // Cursors
  logic [7:0] cursor_x_q, cursor_y_q, saved_x_q, saved_y_q;

  // Window of the character being drawn
  logic [7:0] win_xs_q, win_ys_q, win_xe_q, win_ye_q;

  // Data run counters
  logic [CW-1:0] col_q;
  logic [SW-1:0] sub_q;

  // Glyph memory, one byte per glyph column
  logic [7:0]    glyph_mem [DEPTH];
  logic [7:0]    rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [CW-1:0] rd_col;

  // Handshake helpers
  logic out_free;
  logic out_load;
  logic ch_ok, gc_ok;
  logic col_last, sub_last;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  // a result is loaded into the output register this cycle
  assign out_load    = out_free && (state_q inside {S_CLEAR, S_WIN, S_DATA});

  assign ch_ok    = ({1'b0, item_q.char_code} < 9'(GLYPH_COUNT));
  assign gc_ok    = ({1'b0, item_q.glyph_column} < 4'(GLYPH_COLUMNS));
  assign col_last = (col_q == CW'(GLYPH_COLUMNS - 1));
  assign sub_last = (sub_q == SW'(SUBS - 1));

  // ---------------------------------------------------------------------------
  // Put-character placement: fit check and wrap to next band or top row.
  // Row sums are formed side by side so only one add precedes each compare.
  // ---------------------------------------------------------------------------
  logic [7:0] end_x0, y_next, y_next_end, top_end, cur_end;
  logic       wrap, wrap_top;
  logic [7:0] win_xs_d, win_ys_d, win_xe_d, win_ye_d;

  always_comb begin
    end_x0     = cursor_x_q + WIDTH_PX;
    y_next     = cursor_y_q + STEP_1;
    y_next_end = cursor_y_q + STEP_2;
    top_end    = area_top_q + STEP_1;
    cur_end    = cursor_y_q + STEP_1;
    wrap       = (end_x0 > area_right_q);
    wrap_top   = (y_next_end > area_bottom_q);
    if (wrap) begin
      win_xs_d = area_left_q;
      win_xe_d = area_left_q + WIDTH_PX;
      win_ys_d = wrap_top ? area_top_q : y_next;
      win_ye_d = wrap_top ? top_end : y_next_end;
    end else begin
      win_xs_d = cursor_x_q;
      win_xe_d = end_x0;
      win_ys_d = cursor_y_q;
      win_ye_d = cur_end;
    end
  end

  // Set-cursor position, 8-bit wrapped, falling back to the area origin
  logic [15:0] prod_x, prod_y;
  logic [7:0]  set_x, set_y;

  always_comb begin
    prod_x = 16'(item_q.text_col) * 16'(GLYPH_COLUMNS * SCALE);
    prod_y = 16'(item_q.text_row) * 16'(ROW_STEP);
    set_x  = area_left_q + prod_x[7:0];
    set_y  = area_top_q + prod_y[7:0];
  end

  // ---------------------------------------------------------------------------
  // Pixel byte: replicate each bit SCALE times, LSB first, then pick the half
  // ---------------------------------------------------------------------------
  logic [7:0]             line;
  logic [8*MAX_SCALE-1:0] wide;
  logic                   hi_half;
  logic [7:0]             pix;

  always_comb begin
    line = ch_ok ? rdata_q : 8'h00;
    wide = '0;
    for (int b = 0; b < 8; b++) begin
      for (int s = 0; s < SCALE; s++) begin
        wide[b*SCALE+s] = line[b];
      end
    end
    hi_half = (SCALE > 1) ? sub_q[0] : 1'b0;
    pix     = hi_half ? wide[15:8] : wide[7:0];
  end

  // ---------------------------------------------------------------------------
  // Glyph memory port: write on glyph-byte items, read column 0 while decoding
  // and the next column as the last byte of the current one leaves.
  // ---------------------------------------------------------------------------
  always_comb begin
    rd_col    = (state_q == S_EXEC) ? '0 : col_q + CW'(1);
    mem_waddr = AW'(item_q.char_code) * AW'(GLYPH_COLUMNS) + AW'(item_q.glyph_column);
    mem_raddr = AW'(item_q.char_code) * AW'(GLYPH_COLUMNS) + AW'(rd_col);
    mem_we    = (state_q == S_EXEC) && (item_q.opcode == OP_GLYPH_WRITE) && ch_ok && gc_ok;
    mem_re    = ch_ok &&
                (((state_q == S_EXEC) && (item_q.opcode == OP_PUT_CHAR)) ||
                 ((state_q == S_DATA) && out_free && sub_last && !col_last));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      glyph_mem[mem_waddr] <= item_q.glyph_bits;
    end
    if (mem_re) begin
      rdata_q <= glyph_mem[mem_raddr];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_left_q   <= AREA_LEFT_RST;
      area_top_q    <= AREA_TOP_RST;
      area_right_q  <= AREA_RIGHT_RST;
      area_bottom_q <= AREA_BOTTOM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_AREA_LEFT:   area_left_q   <= cfg_data_i;
        CFG_AREA_TOP:    area_top_q    <= cfg_data_i;
        CFG_AREA_RIGHT:  area_right_q  <= cfg_data_i;
        CFG_AREA_BOTTOM: area_bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: state, cursors and the output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      saved_x_q   <= '0;
      saved_y_q   <= '0;
      col_q       <= '0;
      sub_q       <= '0;
      item_q      <= '0;
      out_q       <= '0;
      win_xs_q    <= '0;
      win_ys_q    <= '0;
      win_xe_q    <= '0;
      win_ye_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= (item_q.opcode == OP_PUT_CHAR) ? (wrap ? S_CLEAR : S_WIN) : S_IDLE;
          case (item_q.opcode)
            OP_PUT_CHAR: begin
              win_xs_q   <= win_xs_d;
              win_ys_q   <= win_ys_d;
              win_xe_q   <= win_xe_d;
              win_ye_q   <= win_ye_d;
              cursor_x_q <= win_xe_d;
              cursor_y_q <= win_ys_d;
              col_q      <= '0;
              sub_q      <= '0;
            end
            OP_SET_CURSOR: begin
              cursor_x_q <= (set_x > area_right_q) ? area_left_q : set_x;
              cursor_y_q <= (set_y > area_bottom_q) ? area_top_q : set_y;
            end
            OP_SAVE_CURSOR: begin
              saved_x_q <= cursor_x_q;
              saved_y_q <= cursor_y_q;
            end
            OP_REST_CURSOR: begin
              cursor_x_q <= saved_x_q;
              cursor_y_q <= saved_y_q;
            end
            default: ;  // glyph write handled at the memory port, others ignored
          endcase
        end
        S_CLEAR: begin
          if (out_free) begin
            out_q.kind       <= KIND_CLEAR;
            out_q.x_start    <= area_left_q;
            out_q.y_start    <= win_ys_q;
            out_q.x_end      <= area_right_q;
            out_q.y_end      <= win_ye_q;
            out_q.pixel_byte <= 8'h00;
            out_q.last       <= 1'b0;
            state_q          <= S_WIN;
          end
        end
        S_WIN: begin
          if (out_free) begin
            out_q.kind       <= KIND_WINDOW;
            out_q.x_start    <= win_xs_q;
            out_q.y_start    <= win_ys_q;
            out_q.x_end      <= win_xe_q;
            out_q.y_end      <= win_ye_q;
            out_q.pixel_byte <= 8'h00;
            out_q.last       <= 1'b0;
            state_q          <= S_DATA;
          end
        end
        S_DATA: begin
          if (out_free) begin
            out_q.kind       <= KIND_PIXELS;
            out_q.x_start    <= 8'h00;
            out_q.y_start    <= 8'h00;
            out_q.x_end      <= 8'h00;
            out_q.y_end      <= 8'h00;
            out_q.pixel_byte <= pix;
            out_q.last       <= col_last && sub_last;
            if (sub_last) begin
              sub_q <= '0;
              if (col_last) begin
                state_q <= S_IDLE;
              end else begin
                col_q <= col_q + CW'(1);
              end
            end else begin
              sub_q <= sub_q + SW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
